FILE: sv/grl_pkg.sv
// Package: shared types and constants for the grid region labeling block.
`default_nettype none
package grl_pkg;
  localparam int MAX_SIDE_DEF = 128;
  localparam int LABEL_W = 14;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 8'd1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [3:0] DOP_NONE      = 4'd0;
  localparam logic [3:0] DOP_LOAD      = 4'd1;
  localparam logic [3:0] DOP_READ      = 4'd2;
  localparam logic [3:0] DOP_CLEAR     = 4'd3;
  localparam logic [3:0] DOP_SCAN      = 4'd4;
  localparam logic [3:0] DOP_SEED      = 4'd5;
  localparam logic [3:0] DOP_POP       = 4'd6;
  localparam logic [3:0] DOP_NBR_ADDR  = 4'd7;
  localparam logic [3:0] DOP_NBR_TEST  = 4'd8;
  localparam logic [3:0] DOP_FINISH    = 4'd9;
  localparam logic [3:0] DOP_CFG       = 4'd10;

  typedef struct packed {
    logic [3:0] op;
  } grl_cmd_t;

  typedef struct packed {
    logic load_done;     // last cell stored
    logic clear_done;
    logic scan_done;
    logic scan_seed;     // current scan cell starts a region
    logic stack_empty;
    logic nbr_last;      // last neighbour offset
    logic labeled;
  } grl_stat_t;
endpackage
`default_nettype wire

FILE: sv/grl_ctrl.sv
// Controller: sequences loads, reads, label clearing and flood fill.
`default_nettype none
module grl_ctrl
  import grl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      command,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  grl_stat_t      stat,
  output grl_cmd_t       cmd
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_CLEAR = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_POP   = 4'd4;
  localparam logic [3:0] S_NADDR = 4'd5;
  localparam logic [3:0] S_NTEST = 4'd6;
  localparam logic [3:0] S_SWAIT = 4'd7;
  localparam logic [3:0] S_PWAIT = 4'd8;

  logic [3:0] state, state_next;
  logic out_valid_next;
  logic take_in;

  assign in_ready  = (state == S_IDLE) && !out_valid;
  assign cfg_ready = (state == S_IDLE) && !in_valid && !out_valid;
  assign take_in   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = DOP_NONE;
    unique case (state)
      S_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          cmd.op = DOP_CFG;
        end else if (take_in) begin
          if (command == CMD_LOAD) begin
            cmd.op = DOP_LOAD;
            if (stat.load_done) state_next = S_CLEAR;
            else out_valid_next = 1'b1;
          end else begin
            cmd.op = DOP_READ;
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      S_CLEAR: begin
        cmd.op = DOP_CLEAR;
        if (stat.clear_done) state_next = S_SWAIT;
      end
      S_SWAIT: begin
        // wait for the scan cell's registered reads
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          cmd.op = DOP_FINISH;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end else if (stat.scan_seed) begin
          cmd.op = DOP_SEED;
          state_next = S_PWAIT;
        end else begin
          cmd.op = DOP_SCAN;
          state_next = S_SWAIT;
        end
      end
      S_PWAIT: begin
        // wait for the registered stack top
        state_next = S_POP;
      end
      S_POP: begin
        if (stat.stack_empty) begin
          cmd.op = DOP_SCAN;
          state_next = S_SWAIT;
        end else begin
          cmd.op = DOP_POP;
          state_next = S_NADDR;
        end
      end
      S_NADDR: begin
        cmd.op = DOP_NBR_ADDR;
        state_next = S_NTEST;
      end
      S_NTEST: begin
        cmd.op = DOP_NBR_TEST;
        state_next = stat.nbr_last ? S_PWAIT : S_NADDR;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

FILE: sv/grl_dpath.sv
// Datapath: cell map, label store, fill stack, counters and result register.
`default_nettype none
module grl_dpath
  import grl_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  grl_cmd_t                  cmd,
  output grl_stat_t                 stat,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 cell_pathable,
  input  wire logic [13:0]          cell_index,
  output logic [12:0]               region_label,
  output logic                      in_region,
  output logic [13:0]               region_count,
  output logic                      labels_ready
);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = $clog2(MAX_SIDE) * 2;
  localparam int NC = MAX_SIDE * MAX_SIDE;
  localparam int TW = CW + 1;
  localparam int XW = $clog2(MAX_SIDE);

  logic [7:0] grid_width, grid_height;
  logic [SW-1:0] w_eff, h_eff;
  logic [TW-1:0] total;

  always_comb begin
    if (grid_width == 8'd0) w_eff = SW'(1);
    else if (32'(grid_width) > MAX_SIDE) w_eff = SW'(MAX_SIDE);
    else w_eff = SW'(grid_width);
    if (grid_height == 8'd0) h_eff = SW'(1);
    else if (32'(grid_height) > MAX_SIDE) h_eff = SW'(MAX_SIDE);
    else h_eff = SW'(grid_height);
    total = TW'(w_eff) * TW'(h_eff);
  end

  // memories
  logic            pmap [NC];
  logic [LABEL_W-1:0] lab_mem [NC];
  logic            lvalid [NC];
  logic [CW-1:0]   stk [NC];

  logic [TW-1:0] loaded_cells;
  logic [LABEL_W-1:0] next_region;
  logic [TW-1:0] scan_pos;
  logic [TW-1:0] clr_pos;
  logic          labeled;
  logic [TW-1:0] sp;

  logic          p_rd, v_rd;
  logic [LABEL_W-1:0] l_rd;

  // current fill cell coordinates
  logic [XW-1:0] cx, cy;
  logic [3:0]    nbr;
  logic [XW:0]   nx, ny;
  logic          n_ok;
  logic [CW-1:0] n_addr;
  logic [CW-1:0] rd_addr;
  logic [CW-1:0] stk_top;
  logic [XW:0]   scan_x;
  logic [XW:0]   scan_y;
  logic [XW:0]   dx_s, dy_s;
  logic          n_ok_r;
  logic [CW-1:0] n_addr_r;
  logic [CW-1:0] n_xy_r;
  logic          rd_ok;
  logic          rd_pend;
  logic          filling;

  always_comb begin
    dx_s = (nbr == 4'd0 || nbr == 4'd3 || nbr == 4'd5) ? {(XW+1){1'b1}} :
           (nbr == 4'd1 || nbr == 4'd6) ? '0 : (XW+1)'(1);
    dy_s = (nbr <= 4'd2) ? {(XW+1){1'b1}} : (nbr >= 4'd5) ? (XW+1)'(1) : '0;
    nx = {1'b0, cx} + dx_s;
    ny = {1'b0, cy} + dy_s;
    n_ok = (nx < (XW+1)'(w_eff)) && (ny < (XW+1)'(h_eff));
    n_addr = CW'(ny[XW-1:0]) * CW'(w_eff) + CW'(nx[XW-1:0]);
  end

  always_comb begin
    unique case (cmd.op)
      DOP_READ:     rd_addr = CW'(cell_index);
      DOP_NBR_ADDR: rd_addr = n_addr;
      default:      rd_addr = scan_pos[CW-1:0];
    endcase
  end

  logic rd_inrange;
  assign rd_inrange = (32'(cell_index) < 32'(total)) && (32'(cell_index) < NC);

  always_ff @(posedge clk) begin
    p_rd <= pmap[rd_addr];
    v_rd <= lvalid[rd_addr];
    l_rd <= lab_mem[rd_addr];
    stk_top <= stk[CW'(sp - TW'(1))];
  end

  assign stat.load_done   = labeled ? (total == TW'(1)) :
                                      (loaded_cells + TW'(1) >= total);
  assign stat.clear_done  = (clr_pos == TW'(NC - 1));
  assign stat.scan_done   = (scan_pos >= total);
  assign stat.scan_seed   = p_rd && !v_rd;
  assign stat.stack_empty = (sp == '0);
  assign stat.nbr_last    = (nbr == 4'd7);
  assign stat.labeled     = labeled;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= 8'd128;
      grid_height <= 8'd128;
      loaded_cells <= '0;
      next_region <= '0;
      labeled <= 1'b0;
      scan_pos <= '0;
      scan_x <= '0;
      scan_y <= '0;
      clr_pos <= '0;
      sp <= '0;
      nbr <= '0;
      rd_ok <= 1'b0;
      rd_pend <= 1'b0;
      filling <= 1'b0;
    end else begin
      unique case (cmd.op)
        DOP_CFG: begin
          if (cfg_index == REG_WIDTH) grid_width <= cfg_data;
          if (cfg_index == REG_HEIGHT) grid_height <= cfg_data;
          if (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT) begin
            loaded_cells <= '0;
            next_region <= '0;
            labeled <= 1'b0;
          end
        end
        DOP_LOAD: begin
          if (labeled) begin
            labeled <= 1'b0;
            next_region <= '0;
            loaded_cells <= TW'(1);
            pmap[0] <= cell_pathable;
          end else begin
            loaded_cells <= loaded_cells + TW'(1);
            if (32'(loaded_cells) < NC) pmap[CW'(loaded_cells)] <= cell_pathable;
          end
          clr_pos <= '0;
          scan_pos <= '0;
          scan_x <= '0;
          scan_y <= '0;
        end
        DOP_READ: rd_ok <= labeled && rd_inrange;
        DOP_CLEAR: begin
          lvalid[CW'(clr_pos)] <= 1'b0;
          clr_pos <= clr_pos + TW'(1);
        end
        DOP_SCAN: begin
          scan_pos <= scan_pos + TW'(1);
          if (scan_x + (XW+1)'(1) == (XW+1)'(w_eff)) begin
            scan_x <= '0;
            scan_y <= scan_y + (XW+1)'(1);
          end else begin
            scan_x <= scan_x + (XW+1)'(1);
          end
          if (filling) begin
            next_region <= next_region + LABEL_W'(1);
            filling <= 1'b0;
          end
        end
        DOP_SEED: begin
          lab_mem[CW'(scan_pos)] <= next_region;
          lvalid[CW'(scan_pos)] <= 1'b1;
          stk[0] <= {scan_y[XW-1:0], scan_x[XW-1:0]};
          sp <= TW'(1);
          filling <= 1'b1;
        end
        DOP_POP: begin
          cx <= stk_top[XW-1:0];
          cy <= stk_top[CW-1:XW];
          sp <= sp - TW'(1);
          nbr <= '0;
        end
        DOP_NBR_ADDR: begin
          n_ok_r <= n_ok;
          n_addr_r <= n_addr;
          n_xy_r <= {ny[XW-1:0], nx[XW-1:0]};
        end
        DOP_NBR_TEST: begin
          if (n_ok_r && p_rd && !v_rd) begin
            lab_mem[n_addr_r] <= next_region;
            lvalid[n_addr_r] <= 1'b1;
            stk[CW'(sp)] <= n_xy_r;
            sp <= sp + TW'(1);
          end
          nbr <= nbr + 4'd1;
        end
        DOP_FINISH: labeled <= 1'b1;
        default: ;
      endcase
      rd_pend <= (cmd.op == DOP_READ);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == DOP_LOAD || cmd.op == DOP_FINISH) begin
      region_label <= '0;
      in_region <= 1'b0;
    end else if (rd_pend) begin
      region_label <= (rd_ok && p_rd && v_rd) ? l_rd[12:0] : '0;
      in_region <= rd_ok && p_rd && v_rd;
    end
  end
  assign region_count = labeled ? next_region : '0;
  assign labels_ready = labeled;
endmodule
`default_nettype wire

FILE: sv/grid_region_labeling.sv
// Top level: 8-connected region labeling of a loaded grid.
// Loads a grid one cell per input transfer in row-major order, then labels its
// 8-connected regions of pathable cells in scan order, and answers read commands
// with the cell's label, a region flag and the region count. Registers 0 and 1
// set width and height (0 acts as 1, larger than MAX_SIDE is capped); writing
// either drops the grid in progress. Every input transfer gives one result
// transfer, and input is held off while a result waits. The load that completes
// the grid waits for labeling: clearing the whole label store (MAX_SIDE*MAX_SIDE
// entries, 16384 at the default), scanning every grid cell, filling each region
// from its seed cell, and finishing.
`default_nettype none
module grid_region_labeling
  import grl_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 command,
  input  wire logic                 cell_pathable,
  input  wire logic [13:0]          cell_index,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [12:0]               region_label,
  output logic                      in_region,
  output logic [13:0]               region_count,
  output logic                      labels_ready,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);
  grl_cmd_t  cmd;
  grl_stat_t stat;

  grl_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .command, .out_valid, .out_ready,
    .cfg_valid, .cfg_ready, .stat, .cmd
  );

  grl_dpath #(.MAX_SIDE(MAX_SIDE)) u_dpath (
    .clk, .rst, .cmd, .stat, .cfg_index, .cfg_data, .cell_pathable, .cell_index,
    .region_label, .in_region, .region_count, .labels_ready
  );
endmodule
`default_nettype wire

FILE: sim/grid_region_labeling_test.sv
// Testbench for grid_region_labeling: random grids, self-checking against a label predictor.
module grid_region_labeling_test;
  timeunit 1ns;
  timeprecision 1ps;
  import grl_pkg::*;

  localparam int NCELLS = MAX_SIDE_DEF * MAX_SIDE_DEF;
  localparam int STALL_LIMIT = 100000;
  localparam int SETTLE = 60;

  typedef struct {
    logic        cmd;
    logic        pathable;
    logic [13:0] idx;
  } cell_cmd_t;

  typedef struct {
    logic [12:0] lbl;
    logic        inr;
    logic [13:0] cnt;
    logic        rdy;
  } label_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = CMD_LOAD;
  logic cell_pathable = 1'b0;
  logic [13:0] cell_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [12:0] region_label;
  logic in_region;
  logic [13:0] region_count;
  logic labels_ready;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
  logic [7:0] cfg_data = '0;

  grid_region_labeling u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .cell_pathable(cell_pathable), .cell_index(cell_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .region_label(region_label), .in_region(in_region),
    .region_count(region_count), .labels_ready(labels_ready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cell_cmd_t     cmd_q[$];
  label_result_t label_q[$];
  int  accepted = 0;
  int  queued = 0;
  int  errors = 0;
  bit  in_fire = 1'b0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  // predictor state
  logic [7:0]  reg_w = 8'd128;
  logic [7:0]  reg_h = 8'd128;
  bit          pmap[NCELLS];
  logic [13:0] lab_of[NCELLS];
  bit          lab_ok[NCELLS];
  int          fill_stk[NCELLS];
  int          loaded = 0;
  logic [13:0] nregion = '0;
  bit          labeled = 1'b0;

  initial forever #4 clk = ~clk;

  function automatic int eff_side(logic [7:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return int'(v);
  endfunction

  function automatic int idle_mode();
    if (accepted < 550) return 0;
    if (accepted < 1100) return 1;
    return 2;
  endfunction

  task automatic label_grid(int w, int h);
    int sp, c, cx, cy, nx, ny, n;
    for (int i = 0; i < NCELLS; i++) begin
      lab_ok[i] = 1'b0;
      lab_of[i] = '0;
    end
    nregion = '0;
    for (int p = 0; p < w * h; p++) begin
      if (pmap[p] && !lab_ok[p]) begin
        lab_of[p] = nregion;
        lab_ok[p] = 1'b1;
        sp = 0;
        fill_stk[sp] = p;
        sp++;
        while (sp > 0) begin
          sp--;
          c = fill_stk[sp];
          cx = c % w;
          cy = c / w;
          for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
              nx = cx + dx;
              ny = cy + dy;
              if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < w && ny < h) begin
                n = ny * w + nx;
                if (pmap[n] && !lab_ok[n]) begin
                  lab_of[n] = nregion;
                  lab_ok[n] = 1'b1;
                  fill_stk[sp] = n;
                  sp++;
                end
              end
            end
          end
        end
        nregion = nregion + 14'd1;
      end
    end
    labeled = 1'b1;
  endtask

  task automatic predict_cell(cell_cmd_t it, output label_result_t r);
    int w, h;
    w = eff_side(reg_w);
    h = eff_side(reg_h);
    r.lbl = '0;
    r.inr = 1'b0;
    if (it.cmd == CMD_LOAD) begin
      if (labeled) begin
        labeled = 1'b0;
        loaded = 0;
        nregion = '0;
      end
      if (loaded < NCELLS) pmap[loaded] = it.pathable;
      loaded++;
      if (loaded >= w * h) label_grid(w, h);
    end else if (labeled && it.idx < w * h && pmap[it.idx] && lab_ok[it.idx]) begin
      r.lbl = lab_of[it.idx][12:0];
      r.inr = 1'b1;
    end
    r.cnt = nregion;
    r.rdy = labeled;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, accepted);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (cmd_q.size() > 0 &&
          $urandom_range(0, 99) >= (idle_mode() == 0 ? 28 : idle_mode() == 1 ? 53 : 0)) begin
        cell_cmd_t it;
        it = cmd_q.pop_front();
        command <= it.cmd;
        cell_pathable <= it.pathable;
        cell_index <= it.idx;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && idle_mode() == 2 && cmd_q.size() > 20) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(0, 99) >=
                     (idle_mode() == 0 ? 53 : idle_mode() == 1 ? 28 : 0);
      end
    end
  end

  // input transfer: predict
  always @(posedge clk) begin
    label_result_t r;
    cell_cmd_t it;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      it.cmd = command;
      it.pathable = cell_pathable;
      it.idx = cell_index;
      predict_cell(it, r);
      label_q = {label_q, r};
    end
  end

  // monitor
  always @(posedge clk) begin
    label_result_t e;
    if (!rst && out_valid && out_ready) begin
      accepted <= accepted + 1;
      if (label_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = label_q.pop_front();
        if (region_label !== e.lbl)
          report_mismatch("region_label", int'(region_label), int'(e.lbl));
        if (in_region !== e.inr)
          report_mismatch("in_region", int'(in_region), int'(e.inr));
        if (region_count !== e.cnt)
          report_mismatch("region_count", int'(region_count), int'(e.cnt));
        if (labels_ready !== e.rdy)
          report_mismatch("labels_ready", int'(labels_ready), int'(e.rdy));
      end
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("grid_region_labeling verification failed");
      $finish;
    end
  end

  task automatic push_cell(logic cmd, logic p, logic [13:0] idx);
    cell_cmd_t it;
    it.cmd = cmd;
    it.pathable = p;
    it.idx = idx;
    cmd_q = {cmd_q, it};
    queued++;
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || in_valid || label_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_WIDTH) reg_w = val;
    else reg_h = val;
    loaded = 0;
    nregion = '0;
    labeled = 1'b0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_grid(int total);
    int dens;
    dens = $urandom_range(5, 95);
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(0, 19) == 0) push_cell(CMD_READ, 1'($urandom), 14'($urandom));
      push_cell(CMD_LOAD, $urandom_range(0, 99) < dens, 14'($urandom));
    end
    repeat ($urandom_range(8, 36)) begin
      if ($urandom_range(0, 4) == 0) push_cell(CMD_READ, 1'($urandom), 14'($urandom));
      else push_cell(CMD_READ, 1'($urandom), 14'($urandom_range(0, total - 1)));
    end
  endtask

  initial begin
    logic [7:0] w, h;
    int total;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reads before any labeling, then a 3x2 grid with a diagonal link
    push_cell(CMD_READ, 1'b0, 14'd0);
    push_cell(CMD_READ, 1'b1, 14'h3FFF);
    drain();
    write_reg(REG_WIDTH, 8'd3);
    write_reg(REG_HEIGHT, 8'd2);
    push_cell(CMD_LOAD, 1'b1, 14'h3FFF);
    push_cell(CMD_LOAD, 1'b0, 14'd0);
    push_cell(CMD_LOAD, 1'b1, 14'd0);
    push_cell(CMD_READ, 1'b0, 14'd0);
    push_cell(CMD_LOAD, 1'b0, 14'd0);
    push_cell(CMD_LOAD, 1'b1, 14'd0);
    push_cell(CMD_LOAD, 1'b0, 14'd0);
    for (int i = 0; i < 8; i++) push_cell(CMD_READ, 1'b1, i[13:0]);
    push_cell(CMD_READ, 1'b0, 14'h3FFF);
    push_cell(CMD_LOAD, 1'b1, 14'd0);
    push_cell(CMD_READ, 1'b0, 14'd0);
    drain();

    while (queued < 1625) begin
      case ($urandom_range(0, 9))
        0: begin
          w = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          h = 8'($urandom_range(1, 2));
        end
        1: begin
          w = 8'($urandom_range(1, 2));
          h = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        2: begin w = 8'd128; h = 8'd1; end
        3: begin w = 8'd1; h = 8'd128; end
        default: begin w = 8'($urandom_range(1, 12)); h = 8'($urandom_range(1, 12)); end
      endcase
      write_reg(REG_WIDTH, w);
      if ($urandom_range(0, 3) != 0 || h != reg_h) write_reg(REG_HEIGHT, h);
      total = eff_side(reg_w) * eff_side(reg_h);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(0, total - 1))
          push_cell(CMD_LOAD, 1'($urandom), 14'($urandom));
        push_cell(CMD_READ, 1'($urandom), 14'($urandom));
      end else begin
        random_grid(total);
        if ($urandom_range(0, 2) == 0) random_grid(total);
      end
      drain();
    end

    if (errors == 0 && label_q.size() == 0) begin
      $display("grid_region_labeling verification clean");
    end else begin
      $display("grid_region_labeling verification failed");
    end
    $finish;
  end
endmodule
